// ===== hw/rtl/feature_grid_suppression_assert.svh =====
// ----------------------------------------------------------------------------
// feature_grid_suppression assertion macros
// Shared property shapes for the port-level checker
// ----------------------------------------------------------------------------
`ifndef FEATURE_GRID_SUPPRESSION_ASSERT_SVH
`define FEATURE_GRID_SUPPRESSION_ASSERT_SVH

// same-cycle implication, quiet during reset
`define FGS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define FGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// state right after a reset cycle
`define FGS_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fgs_pkg.sv =====
// ----------------------------------------------------------------------------
// fgs_pkg
// Types, widths and constants shared by the feature grid suppression block
// ----------------------------------------------------------------------------
package fgs_pkg;

    localparam int POS_W     = 13;
    localparam int COORD_W   = 12;
    localparam int SIZE_W    = 12;
    localparam int DIST_W    = 7;
    localparam int ID_W      = 32;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_CNT_W = $clog2(COORD_W + 1);

    localparam int WORD_W  = 32;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int EPOCH_W = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DEF_CELL_COLS = 256;
    localparam int DEF_CELL_ROWS = 256;

    localparam int EDGE_PX  = 10;
    localparam int NEED_CAP = 20;

    localparam logic [SIZE_W-1:0] RST_IMG_WIDTH  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] RST_IMG_HEIGHT = SIZE_W'(480);
    localparam logic [DIST_W-1:0] RST_MIN_DIST   = DIST_W'(10);
    localparam logic [SIZE_W-1:0] RST_TARGET     = SIZE_W'(200);

    typedef enum logic [1:0] {
        FN_FRAME = 2'd0,
        FN_TRACK = 2'd1,
        FN_CAND  = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_MIN_DIST = 2'd2,
        CFG_TARGET   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        BS_SWEEP,
        BS_IDLE,
        BS_DIV,
        BS_READ,
        BS_CHECK,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic [SIZE_W-1:0] img_width;
        logic [SIZE_W-1:0] img_height;
        logic [DIST_W-1:0] min_dist;
        logic [SIZE_W-1:0] target;
    } t_cfg;

    typedef struct packed {
        t_func              func;
        logic               pre_ok;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ID_W-1:0]    pid;
    } t_entry;

    typedef struct packed {
        logic [COORD_W-1:0] quo;
        logic [DIST_W-1:0]  rem;
        logic               done;
    } t_div_res;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== hw/rtl/fgs_divider.sv =====
// ----------------------------------------------------------------------------
// fgs_divider
// Restoring divider, one quotient bit per cycle, coordinate by cell size
// ----------------------------------------------------------------------------
module fgs_divider
    import fgs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COORD_W-1:0] i_dividend,
    input  logic [DIST_W-1:0]  i_divisor,
    output t_div_res           o_res
);

    logic [COORD_W-1:0]   r_quo;
    logic [DIST_W-1:0]    r_rem;
    logic [DIST_W-1:0]    r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIST_W:0]      trial;
    logic [DIST_W:0]      diff;
    logic                 ge;
    logic [COORD_W-1:0]   n_quo;
    logic [DIST_W-1:0]    n_rem;

    always_comb begin
        trial = {r_rem, r_quo[COORD_W-1]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
        n_rem = ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
        n_quo = {r_quo[COORD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(COORD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_res = '{quo: r_quo, rem: r_rem, done: r_done};

endmodule

// ===== hw/rtl/fgs_front.sv =====
// ----------------------------------------------------------------------------
// fgs_front
// Input side: takes words, checks sign and image border, queues the item
// ----------------------------------------------------------------------------
module fgs_front
    import fgs_pkg::*;
(
    input  logic                    i_in_valid,
    input  logic [1:0]              i_func,
    input  logic signed [POS_W-1:0] i_x_pos,
    input  logic signed [POS_W-1:0] i_y_pos,
    input  logic [ID_W-1:0]         i_point_id,
    input  t_cfg                    i_cfg,
    input  t_qstat                  i_qstat,
    input  logic                    i_sweeping,
    output logic                    o_in_stall,
    output logic                    o_push,
    output t_entry                  o_entry
);

    localparam logic signed [POS_W:0] BORDER_LO = (POS_W+1)'(EDGE_PX);

    logic signed [POS_W:0] xs;
    logic signed [POS_W:0] ys;
    logic signed [POS_W:0] w_lim;
    logic signed [POS_W:0] h_lim;
    logic                  pos_ok;
    logic                  border_ok;
    logic                  pre_ok;
    t_func                 func;

    always_comb begin
        func      = t_func'(i_func);
        xs        = (POS_W+1)'(i_x_pos);
        ys        = (POS_W+1)'(i_y_pos);
        w_lim     = $signed((POS_W+1)'(i_cfg.img_width)) - BORDER_LO;
        h_lim     = $signed((POS_W+1)'(i_cfg.img_height)) - BORDER_LO;
        pos_ok    = !i_x_pos[POS_W-1] && !i_y_pos[POS_W-1];
        border_ok = (xs >= BORDER_LO) && (xs < w_lim) && (ys >= BORDER_LO) && (ys < h_lim);
        unique case (func)
            FN_TRACK: pre_ok = pos_ok && border_ok;
            FN_CAND:  pre_ok = pos_ok;
            default:  pre_ok = 1'b0;
        endcase
    end

    assign o_in_stall = i_qstat.full | i_sweeping;
    assign o_push     = i_in_valid & !o_in_stall;

    assign o_entry = '{
        func:   func,
        pre_ok: pre_ok,
        x:      i_x_pos[COORD_W-1:0],
        y:      i_y_pos[COORD_W-1:0],
        pid:    i_point_id
    };

endmodule

// ===== hw/rtl/fgs_queue.sv =====
// ----------------------------------------------------------------------------
// fgs_queue
// Short item queue between the front and the back end
// ----------------------------------------------------------------------------
module fgs_queue
    import fgs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output t_qstat o_qstat
);

    t_entry            r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

    assign o_entry       = r_slot[r_rptr];
    assign o_qstat.full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_qstat.empty = r_count == '0;

endmodule

// ===== hw/rtl/fgs_back.sv =====
// ----------------------------------------------------------------------------
// fgs_back
// Back end: cell lookup, occupancy map, counters and the output register
// ----------------------------------------------------------------------------
module fgs_back
    import fgs_pkg::*;
#(
    parameter int MAX_CELL_COLS = DEF_CELL_COLS,
    parameter int MAX_CELL_ROWS = DEF_CELL_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_qstat            i_qstat,
    input  t_entry            i_entry,
    output logic              o_pop,
    output logic              o_sweeping,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_kept,
    output logic [ID_W-1:0]   o_out_id,
    output logic [SIZE_W-1:0] o_kept_count,
    output logic              o_needs_more
);

    localparam int MAP_BITS = MAX_CELL_COLS * MAX_CELL_ROWS;
    localparam int DEPTH    = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int IDX_W    = $clog2(MAP_BITS);
    localparam int MEM_W    = EPOCH_W + WORD_W;

    localparam logic [ADDR_W-1:0]  SWEEP_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [COORD_W:0]   COLS_LIM   = (COORD_W+1)'(MAX_CELL_COLS);
    localparam logic [COORD_W:0]   ROWS_LIM   = (COORD_W+1)'(MAX_CELL_ROWS);
    localparam logic [SIZE_W-1:0]  CAP        = SIZE_W'(NEED_CAP);

    t_bstate             r_state;
    t_bstate             n_state;
    t_entry              r_item;
    logic [ADDR_W-1:0]   r_sweep_addr;
    logic                r_sweep_req;
    logic [EPOCH_W-1:0]  r_epoch;
    logic [SIZE_W-1:0]   r_kept_total;
    logic [ID_W-1:0]     r_next_id;
    logic [ADDR_W-1:0]   r_addr;
    logic [BIT_W-1:0]    r_bit;
    logic [MEM_W-1:0]    r_rd_word;
    logic                r_res_kept;
    logic [ID_W-1:0]     r_res_id;
    logic                r_out_valid;
    logic                r_out_kept;
    logic [ID_W-1:0]     r_out_id;
    logic [SIZE_W-1:0]   r_out_count;
    logic                r_out_needs;
    logic [MEM_W-1:0]    r_mem [DEPTH];

    logic [DIST_W-1:0]   md_eff;
    t_div_res            div_x;
    t_div_res            div_y;
    logic                div_done;
    logic                pop;
    logic                div_start;
    logic                mem_rd;
    logic                mem_wr;
    logic                mark;
    logic                load_out;
    logic                sweep_step;

    logic [COORD_W-1:0]  x_lo;
    logic [COORD_W-1:0]  y_lo;
    logic [COORD_W:0]    span_x;
    logic [COORD_W:0]    span_y;
    logic                cell_ok;
    logic [IDX_W-1:0]    idx;

    logic                tag_hit;
    logic [WORD_W-1:0]   cur_bits;
    logic                taken;
    logic [MEM_W-1:0]    upd_word;
    logic [ADDR_W-1:0]   wr_addr;
    logic [MEM_W-1:0]    wr_data;

    logic signed [SIZE_W:0] need;
    logic [SIZE_W-1:0]      half;
    logic [SIZE_W-1:0]      thr;
    logic                   needs;

    assign md_eff = (i_cfg.min_dist == '0) ? DIST_W'(1) : i_cfg.min_dist;

    fgs_divider u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_entry.x),
        .i_divisor  (md_eff),
        .o_res      (div_x)
    );

    fgs_divider u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_entry.y),
        .i_divisor  (md_eff),
        .o_res      (div_y)
    );

    assign div_done = div_x.done & div_y.done;

    // cell inside grid: (cell + 1) * md must not pass the image size
    always_comb begin
        x_lo    = r_item.x - COORD_W'(div_x.rem);
        y_lo    = r_item.y - COORD_W'(div_y.rem);
        span_x  = (COORD_W+1)'(x_lo) + (COORD_W+1)'(md_eff);
        span_y  = (COORD_W+1)'(y_lo) + (COORD_W+1)'(md_eff);
        cell_ok = (span_x <= (COORD_W+1)'(i_cfg.img_width))
               && (span_y <= (COORD_W+1)'(i_cfg.img_height))
               && ({1'b0, div_x.quo} < COLS_LIM)
               && ({1'b0, div_y.quo} < ROWS_LIM);
        idx     = IDX_W'(div_y.quo) * IDX_W'(MAX_CELL_COLS) + IDX_W'(div_x.quo);
    end

    // stale epoch tag reads as an empty word
    always_comb begin
        tag_hit  = r_rd_word[MEM_W-1 -: EPOCH_W] == r_epoch;
        cur_bits = tag_hit ? r_rd_word[WORD_W-1:0] : '0;
        taken    = cur_bits[r_bit];
        upd_word = {r_epoch, cur_bits | (WORD_W'(1) << r_bit)};
    end

    always_comb begin
        need  = $signed({1'b0, i_cfg.target}) - $signed({1'b0, r_kept_total});
        half  = i_cfg.target >> 1;
        thr   = (half > CAP) ? CAP : half;
        needs = need >= $signed({1'b0, thr});
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_SWEEP: begin
                if (r_sweep_addr == SWEEP_LAST) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = div_start ? BS_DIV : BS_DONE;
                end
            end
            BS_DIV: begin
                if (div_done) begin
                    n_state = cell_ok ? BS_READ : BS_DONE;
                end
            end
            BS_READ:  n_state = BS_CHECK;
            BS_CHECK: n_state = BS_DONE;
            BS_DONE: begin
                if (load_out) begin
                    n_state = r_sweep_req ? BS_SWEEP : BS_IDLE;
                end
            end
            default:  n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        sweep_step = r_state == BS_SWEEP;
        pop        = (r_state == BS_IDLE) && !i_qstat.empty;
        div_start  = pop && i_entry.pre_ok
                  && ((i_entry.func == FN_TRACK) || (i_entry.func == FN_CAND));
        mem_rd     = r_state == BS_READ;
        mark       = (r_state == BS_CHECK) && !taken;
        mem_wr     = sweep_step | mark;
        load_out   = (r_state == BS_DONE) && (!r_out_valid || !i_out_stall);
        wr_addr    = sweep_step ? r_sweep_addr : r_addr;
        wr_data    = sweep_step ? {r_epoch, {WORD_W{1'b0}}} : upd_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_SWEEP;
            r_sweep_addr <= '0;
            r_sweep_req  <= 1'b0;
            r_epoch      <= '0;
            r_kept_total <= '0;
            r_next_id    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (sweep_step) begin
                r_sweep_addr <= (r_sweep_addr == SWEEP_LAST) ? '0 : r_sweep_addr + 1'b1;
            end
            if (pop && (i_entry.func == FN_FRAME)) begin
                r_kept_total <= '0;
                r_epoch      <= r_epoch + 1'b1;
                if (r_epoch == '1) begin
                    r_sweep_req <= 1'b1;
                end
            end
            if (load_out && r_sweep_req) begin
                r_sweep_req <= 1'b0;
            end
            if (mark) begin
                if (r_kept_total != '1) begin
                    r_kept_total <= r_kept_total + 1'b1;
                end
                if (r_item.func == FN_CAND) begin
                    r_next_id <= r_next_id + 1'b1;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item     <= i_entry;
            r_res_kept <= 1'b0;
            r_res_id   <= '0;
        end
        if (r_state == BS_DIV) begin
            r_addr <= ADDR_W'(idx >> BIT_W);
            r_bit  <= idx[BIT_W-1:0];
        end
        if (mark) begin
            r_res_kept <= 1'b1;
            r_res_id   <= (r_item.func == FN_CAND) ? r_next_id + 1'b1 : r_item.pid;
        end
        if (load_out) begin
            r_out_kept  <= r_res_kept;
            r_out_id    <= r_res_id;
            r_out_count <= r_kept_total;
            r_out_needs <= needs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (mem_rd) begin
            r_rd_word <= r_mem[r_addr];
        end
    end

    assign o_pop        = pop;
    assign o_sweeping   = sweep_step;
    assign o_out_valid  = r_out_valid;
    assign o_kept       = r_out_kept;
    assign o_out_id     = r_out_id;
    assign o_kept_count = r_out_count;
    assign o_needs_more = r_out_needs;

endmodule

// ===== hw/rtl/feature_grid_suppression.sv =====
// ----------------------------------------------------------------------------
// feature_grid_suppression
// Per-frame spacing filter for tracked feature points and corner candidates
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one word per point or frame
// start; output channel (o_out_valid / i_out_stall) returns one word per input.
// Config writes go through i_cfg_valid / o_cfg_ready with i_cfg_index and
// i_cfg_data, always ready; they must be made only while the block is idle,
// which the block itself does not enforce. A point word passes through a
// dequeue, the bit-serial cell divider over the 12 coordinate bits (x and y
// in parallel), a decision, a registered map read, a check-and-mark and the
// output load; the back end takes the next word only once its last result
// is loaded. Frame starts, unused codes and points rejected at the front
// skip the divider. A two-word queue lets the front keep taking words while
// the back works or while the receiver holds i_out_stall; the result then
// waits in the output register and the back end stops once it has the next
// result ready. After reset the occupancy map is cleared in a pass over its
// MAX_CELL_COLS * MAX_CELL_ROWS / 32 words (2048 by default) with o_in_stall
// high; the same pass runs after every 256th frame start.
// ----------------------------------------------------------------------------
module feature_grid_suppression
    import fgs_pkg::*;
#(
    parameter int MAX_CELL_COLS = DEF_CELL_COLS,
    parameter int MAX_CELL_ROWS = DEF_CELL_ROWS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [SIZE_W-1:0]       i_cfg_data,

    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_func,
    input  logic signed [POS_W-1:0] i_x_pos,
    input  logic signed [POS_W-1:0] i_y_pos,
    input  logic [ID_W-1:0]         i_point_id,

    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_kept,
    output logic [ID_W-1:0]         o_out_id,
    output logic [SIZE_W-1:0]       o_kept_count,
    output logic                    o_needs_more
);

    t_cfg   r_cfg;
    t_qstat qstat;
    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   sweeping;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.img_width  <= RST_IMG_WIDTH;
            r_cfg.img_height <= RST_IMG_HEIGHT;
            r_cfg.min_dist   <= RST_MIN_DIST;
            r_cfg.target     <= RST_TARGET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:    r_cfg.img_width  <= i_cfg_data;
                CFG_HEIGHT:   r_cfg.img_height <= i_cfg_data;
                CFG_MIN_DIST: r_cfg.min_dist   <= i_cfg_data[DIST_W-1:0];
                CFG_TARGET:   r_cfg.target     <= i_cfg_data;
                default:      r_cfg            <= r_cfg;
            endcase
        end
    end

    fgs_front u_front (
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_x_pos    (i_x_pos),
        .i_y_pos    (i_y_pos),
        .i_point_id (i_point_id),
        .i_cfg      (r_cfg),
        .i_qstat    (qstat),
        .i_sweeping (sweeping),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    fgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_qstat (qstat)
    );

    fgs_back #(
        .MAX_CELL_COLS (MAX_CELL_COLS),
        .MAX_CELL_ROWS (MAX_CELL_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_qstat      (qstat),
        .i_entry      (head_entry),
        .o_pop        (pop),
        .o_sweeping   (sweeping),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_kept       (o_kept),
        .o_out_id     (o_out_id),
        .o_kept_count (o_kept_count),
        .o_needs_more (o_needs_more)
    );

endmodule

// ===== hw/rtl/fgs_checker.sv =====
// ----------------------------------------------------------------------------
// fgs_checker
// Port-level checks for feature_grid_suppression, bound to the top level
// ----------------------------------------------------------------------------
`include "feature_grid_suppression_assert.svh"

module fgs_checker
    import fgs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_kept,
    input logic [ID_W-1:0]   o_out_id,
    input logic [SIZE_W-1:0] o_kept_count
);

    // held result word
    `FGS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_id), "result word changed under stall")

    // map clear runs right after reset
    `FGS_ASSERT_RESET(a_reset_clear, !o_out_valid && o_in_stall, "no clearing pass after reset")

    // a kept point always counts
    `FGS_ASSERT_NOW(a_kept_count, o_out_valid && o_kept, o_kept_count != '0, "kept point with zero count")

    // rejects carry no id
    `FGS_ASSERT_NOW(a_reject_id, o_out_valid && !o_kept, o_out_id == '0, "rejected word with nonzero id")

endmodule

bind feature_grid_suppression fgs_checker u_fgs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_kept       (o_kept),
    .o_out_id     (o_out_id),
    .o_kept_count (o_kept_count)
);
